// ===== hdl/rgb_led_string_frame_builder_assert.svh =====
// ----------------------------------------------------------------------------
// rgb_led_string_frame_builder_assert.svh
// Assertion macros used by the port-level frame builder checker.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_STRING_FRAME_BUILDER_ASSERT_SVH
`define RGB_LED_STRING_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RLSFB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLSFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rlsfb_pkg.sv =====
// ----------------------------------------------------------------------------
// rlsfb_pkg
// Types and constants of the RGB LED string frame builder.
// ----------------------------------------------------------------------------
package rlsfb_pkg;

  localparam int LED_COUNT_DEF = 16;
  localparam int IDX_W         = 8;
  localparam int COLOR_W       = 8;
  localparam int BRIGHT_W      = 5;
  localparam int WORD_W        = 32;

  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = 5'h1F;
  localparam logic [2:0]          HEADER_BITS = 3'h7;
  localparam logic [WORD_W-1:0]   EDGE_WORD   = 32'h0000_0000;

  typedef enum logic [2:0] {
    OP_COLOR_FULL  = 3'd0,
    OP_COLOR_LEVEL = 3'd1,
    OP_BRIGHT      = 3'd2,
    OP_OFF         = 3'd3,
    OP_ON          = 3'd4,
    OP_UPDATE      = 3'd5
  } op_t;

  // One LED setting, packed in frame order below the header bits.
  typedef struct packed {
    logic [BRIGHT_W-1:0] bright;
    logic [COLOR_W-1:0]  blue;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  red;
  } led_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                wr;
    op_t                 op;
    logic                all;
    logic [IDX_W-1:0]    idx;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
    logic [BRIGHT_W-1:0] level;
    logic                shift;
  } cell_ctl_t;

  function automatic logic is_write(input logic [2:0] code);
    logic res;
    case (code)
      OP_COLOR_FULL, OP_COLOR_LEVEL, OP_BRIGHT, OP_OFF, OP_ON: res = 1'b1;
      default:                                                 res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/rlsfb_cell.sv =====
// ----------------------------------------------------------------------------
// rlsfb_cell
// One LED setting: takes broadcast writes aimed at it, passes its value on
// to its neighbor while the frame is shifted out.
// ----------------------------------------------------------------------------
module rlsfb_cell #(
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  rlsfb_pkg::cell_ctl_t ctl,
  input  rlsfb_pkg::led_t    shift_in,
  output rlsfb_pkg::led_t    val
);
  import rlsfb_pkg::*;

  logic hit;

  assign hit = ctl.wr && (ctl.all || (ctl.idx == IDX_W'(INDEX)));

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else if (ctl.shift) begin
      val <= shift_in;
    end else if (hit) begin
      case (ctl.op)
        OP_COLOR_FULL: begin
          val <= '{bright: BRIGHT_MAX, blue: ctl.blue, green: ctl.green, red: ctl.red};
        end
        OP_COLOR_LEVEL: begin
          val <= '{bright: ctl.level, blue: ctl.blue, green: ctl.green, red: ctl.red};
        end
        OP_BRIGHT: val.bright <= ctl.level;
        OP_OFF:    val.bright <= '0;
        OP_ON:     val.bright <= BRIGHT_MAX;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/rlsfb_seq.sv =====
// ----------------------------------------------------------------------------
// rlsfb_seq
// Frame sequencer: start word, LED words taken from the head of the
// rotating cell chain, end word; holds the output register.
// ----------------------------------------------------------------------------
module rlsfb_seq #(
  parameter int LED_COUNT = rlsfb_pkg::LED_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  rlsfb_pkg::led_t               head,
  input  logic                          out_stall,
  output logic                          busy,
  output logic                          shift,
  output logic                          out_valid,
  output logic [rlsfb_pkg::WORD_W-1:0]  frame_word,
  output logic                          last
);
  import rlsfb_pkg::*;

  localparam int CW = $clog2(LED_COUNT + 2);

  typedef enum logic {IDLE, EMIT} state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          adv;

  assign adv   = !out_valid || !out_stall;
  assign busy  = (state == EMIT);
  assign shift = busy && adv && (cnt != '0) && (cnt <= CW'(LED_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      last      <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (adv) begin
            out_valid <= 1'b0;
          end
          if (start) begin
            state <= EMIT;
            cnt   <= '0;
          end
        end
        EMIT: begin
          if (adv) begin
            out_valid <= 1'b1;
            cnt       <= cnt + CW'(1);
            if (cnt == '0) begin
              frame_word <= EDGE_WORD;
              last       <= 1'b0;
            end else if (cnt <= CW'(LED_COUNT)) begin
              frame_word <= {HEADER_BITS, head};
              last       <= 1'b0;
            end else begin
              frame_word <= EDGE_WORD;
              last       <= 1'b1;
              state      <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/rgb_led_string_frame_builder.sv =====
// ----------------------------------------------------------------------------
// rgb_led_string_frame_builder
// Keeps per-LED brightness and color and builds the serial frame words.
// ----------------------------------------------------------------------------
// Writes: one transaction per cycle while no frame is emitted, settled in the
//   cell chain in the cycle after acceptance. Update that emits: state goes
//   to EMIT, then the output register takes the start word, then one word per
//   cycle when not stalled; LED_COUNT+2 words, input stalled meanwhile (the
//   chain rotates once through its head cell to read out the LEDs).
// Reset: all LEDs brightness and color zero, frame marked as modified.
module rgb_led_string_frame_builder #(
  parameter int LED_COUNT = rlsfb_pkg::LED_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     opcode,
  input  logic [rlsfb_pkg::IDX_W-1:0]    led_index,
  input  logic [rlsfb_pkg::COLOR_W-1:0]  red,
  input  logic [rlsfb_pkg::COLOR_W-1:0]  green,
  input  logic [rlsfb_pkg::COLOR_W-1:0]  blue,
  input  logic [7:0]                     level,
  input  logic                           all_leds,
  input  logic                           force_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rlsfb_pkg::WORD_W-1:0]   frame_word,
  output logic                           last
);
  import rlsfb_pkg::*;

  logic      accept;
  logic      frame_modified;
  logic      start;
  logic      busy;
  logic      shift;
  cell_ctl_t ctl;
  led_t      vals [LED_COUNT];

  // Input side is held off for the whole frame; writes go straight in.
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  // An update emits only when something changed or a resend is forced.
  assign start = accept && (opcode == OP_UPDATE) && (frame_modified || force_req);

  // Every write marks the frame dirty, even one aimed past the string;
  // every update clears it. Undefined opcodes leave it alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_modified <= 1'b1;
    end else if (accept && is_write(opcode)) begin
      frame_modified <= 1'b1;
    end else if (accept && (opcode == OP_UPDATE)) begin
      frame_modified <= 1'b0;
    end
  end

  // Broadcast to the cells. The cell index match filters out-of-range
  // writes, since no cell carries an index at or above LED_COUNT.
  always_comb begin
    ctl.wr    = accept && is_write(opcode);
    ctl.op    = op_t'(opcode);
    ctl.all   = all_leds;
    ctl.idx   = led_index;
    ctl.red   = red;
    ctl.green = green;
    ctl.blue  = blue;
    ctl.level = level[BRIGHT_W-1:0];
    ctl.shift = shift;
  end

  // Cell chain: on each shift every cell takes its upper neighbor's value and
  // the top cell takes cell 0, so LED_COUNT shifts restore the original order.
  for (genvar i = 0; i < LED_COUNT; i++) begin : g_cell
    rlsfb_cell #(
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .shift_in (vals[(i + 1) % LED_COUNT]),
      .val      (vals[i])
    );
  end

  rlsfb_seq #(
    .LED_COUNT (LED_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .head       (vals[0]),
    .out_stall  (out_stall),
    .busy       (busy),
    .shift      (shift),
    .out_valid  (out_valid),
    .frame_word (frame_word),
    .last       (last)
  );

endmodule

// ===== hdl/rlsfb_checker.sv =====
// ----------------------------------------------------------------------------
// rlsfb_checker
// Port-level checks of the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_led_string_frame_builder_assert.svh"

module rlsfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  opcode,
  input logic        force_req,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] frame_word,
  input logic        last
);
  import rlsfb_pkg::*;

  // Stalled output transaction holds.
  `RLSFB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(frame_word) && $stable(last), "output changed under stall")

  // A forced update always starts a frame and holds off input.
  `RLSFB_ASSERT_NEXT(a_force_starts, clk, rst, in_valid && !in_stall && (opcode == OP_UPDATE) && force_req, in_stall, "forced update did not start a frame")

  // Words before the end word are shown only while the frame is running.
  `RLSFB_ASSERT_IMPL(a_mid_busy, clk, rst, out_valid && !last, in_stall, "frame word outside a running frame")

  // When the end word is loaded the input side opens again.
  `RLSFB_ASSERT_IMPL(a_end_free, clk, rst, $rose(out_valid && last), !in_stall, "input still stalled at end word")

endmodule

bind rgb_led_string_frame_builder rlsfb_checker u_rlsfb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .opcode     (opcode),
  .force_req  (force_req),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .frame_word (frame_word),
  .last       (last)
);

// ===== verif/rgb_led_string_frame_builder_checker.sv =====
// ----------------------------------------------------------------------------
// rgb_led_string_frame_builder_checker
// Watches both channels of the frame builder, predicts the frame words and
// compares them in order.
// ----------------------------------------------------------------------------
module rgb_led_string_frame_builder_checker #(
  parameter int LED_COUNT = rlsfb_pkg::LED_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [2:0]                      opcode,
  input  logic [rlsfb_pkg::IDX_W-1:0]     led_index,
  input  logic [rlsfb_pkg::COLOR_W-1:0]   red,
  input  logic [rlsfb_pkg::COLOR_W-1:0]   green,
  input  logic [rlsfb_pkg::COLOR_W-1:0]   blue,
  input  logic [7:0]                      level,
  input  logic                            all_leds,
  input  logic                            force_req,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [rlsfb_pkg::WORD_W-1:0]    frame_word,
  input  logic                            last,
  output int unsigned                     pending,
  output int unsigned                     errors
);
  timeunit 1ns;
  timeprecision 1ps;

  import rlsfb_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } frame_beat_t;

  led_t        led_shadow [LED_COUNT];
  logic        modified_shadow;
  frame_beat_t frame_words_due [$];
  int unsigned mismatch_count = 0;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  // Applies one accepted transaction to the shadow LED store and queues the
  // frame words that an emitting update will produce.
  task automatic track_command();
    frame_beat_t beat;
    case (opcode)
      OP_COLOR_FULL, OP_COLOR_LEVEL, OP_BRIGHT, OP_OFF, OP_ON: begin
        for (int i = 0; i < LED_COUNT; i++) begin
          // out-of-range index never matches, so no LED changes
          if (all_leds || led_index == i) begin
            case (opcode)
              OP_COLOR_FULL: begin
                led_shadow[i].bright = BRIGHT_MAX;
                led_shadow[i].red    = red;
                led_shadow[i].green  = green;
                led_shadow[i].blue   = blue;
              end
              OP_COLOR_LEVEL: begin
                led_shadow[i].bright = level[BRIGHT_W-1:0];
                led_shadow[i].red    = red;
                led_shadow[i].green  = green;
                led_shadow[i].blue   = blue;
              end
              OP_BRIGHT: led_shadow[i].bright = level[BRIGHT_W-1:0];
              OP_OFF:    led_shadow[i].bright = '0;
              default:   led_shadow[i].bright = BRIGHT_MAX;
            endcase
          end
        end
        modified_shadow = 1'b1;
      end
      OP_UPDATE: begin
        if (modified_shadow || force_req) begin
          beat.word = EDGE_WORD;
          beat.last = 1'b0;
          frame_words_due.push_back(beat);
          for (int i = 0; i < LED_COUNT; i++) begin
            beat.word = {HEADER_BITS, led_shadow[i]};
            frame_words_due.push_back(beat);
          end
          beat.word = EDGE_WORD;
          beat.last = 1'b1;
          frame_words_due.push_back(beat);
        end
        modified_shadow = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++) led_shadow[i] = '0;
      modified_shadow = 1'b1;
      frame_words_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_words_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected frame word %h last %b", frame_word, last));
        end else begin
          want = frame_words_due.pop_front();
          if (frame_word !== want.word) begin
            flag_mismatch($sformatf("frame_word: expected %h, got %h", want.word,
                                    frame_word));
          end
          if (last !== want.last) begin
            flag_mismatch($sformatf("last: expected %b, got %b (word %h)", want.last,
                                    last, want.word));
          end
        end
      end
      if (in_valid && !in_stall) track_command();
    end
    pending <= frame_words_due.size();
    errors  <= mismatch_count;
  end

endmodule

// ===== verif/rgb_led_string_frame_builder_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_led_string_frame_builder_tb
// Drives write and update transactions into the frame builder: a directed
// pass over every opcode and corner, then random traffic with bursty input
// and a patterned output stall. A checker beside the DUT scores the frames.
// ----------------------------------------------------------------------------
module rgb_led_string_frame_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlsfb_pkg::*;

  localparam int LED_COUNT = LED_COUNT_DEF;

  // Opcodes the block has no meaning for; they must leave no trace.
  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;

  // Cycles with no transaction on either channel before the run is called hung.
  // Worst legit quiet stretch is a sender gap or a receiver stall run.
  localparam int QUIET_LIMIT   = 4000;
  // After an update is accepted the DUT enters EMIT, then loads the start word.
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_COMMANDS = 450;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSED} rx_mode_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [2:0]        opcode    = '0;
  logic [IDX_W-1:0]  led_index = '0;
  logic [COLOR_W-1:0] red      = '0;
  logic [COLOR_W-1:0] green    = '0;
  logic [COLOR_W-1:0] blue     = '0;
  logic [7:0]        level     = '0;
  logic              all_leds  = 1'b0;
  logic              force_req = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] frame_word;
  logic              last;

  int unsigned pending;
  int unsigned errors;

  int       burst_left   = 0;
  int       quiet_cycles = 0;
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_span      = 0;

  op_t write_ops [5] = '{OP_COLOR_FULL, OP_COLOR_LEVEL, OP_BRIGHT, OP_OFF, OP_ON};

  rgb_led_string_frame_builder #(
    .LED_COUNT(LED_COUNT)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .led_index (led_index),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .level     (level),
    .all_leds  (all_leds),
    .force_req (force_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame_word(frame_word),
    .last      (last)
  );

  rgb_led_string_frame_builder_checker #(
    .LED_COUNT(LED_COUNT)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .led_index (led_index),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .level     (level),
    .all_leds  (all_leds),
    .force_req (force_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame_word(frame_word),
    .last      (last),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: picks a stall pattern, holds it for a random span, then picks
  // again. Open spans give stretches with no backpressure at all; pulsed spans
  // drop the stall only when the span count is a multiple of eight.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_span   <= 0;
    end else if (rx_span == 0) begin
      rx_mode   <= rx_mode_t'($urandom_range(0, 3));
      rx_span   <= $urandom_range(16, 160);
      out_stall <= 1'b0;
    end else begin
      rx_span <= rx_span - 1;
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= (rx_span[2:0] != 0);
      endcase
    end
  end

  // Watchdog: any accepted transaction on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sends one transaction and returns at the edge where it was accepted.
  // The sender runs in bursts; a gap only opens between bursts, so valid is
  // never dropped and raised in the same step.
  task automatic drive_command(input logic [2:0] code, input logic [7:0] idx,
                               input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [7:0] lvl,
                               input logic all, input logic frc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid  <= 1'b1;
    opcode    <= code;
    led_index <= idx;
    red       <= r;
    green     <= g;
    blue      <= b;
    level     <= lvl;
    all_leds  <= all;
    force_req <= frc;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending until every queued frame word has come out. The first edge
  // lets the checker count a frame the last update just queued.
  task automatic wait_frames_out();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [2:0] code;
    logic [7:0] idx;
    int         sel;
    int         sent;
    bit         drained;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // frame is modified out of reset: all-zero LEDs go out
    drive_command(OP_UPDATE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    // nothing changed since: no frame
    drive_command(OP_UPDATE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    // forced: frame even though unmodified
    drive_command(OP_UPDATE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
    drive_command(OP_COLOR_FULL, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1);
    drive_command(OP_COLOR_FULL, 8'(LED_COUNT - 1), 8'h00, 8'hFF, 8'h00, 8'hFF,
                  1'b0, 1'b0);
    // level top bits must be dropped
    drive_command(OP_COLOR_LEVEL, 8'h01, 8'hAA, 8'h55, 8'hFF, 8'hFF, 1'b0, 1'b0);
    drive_command(OP_COLOR_LEVEL, 8'h02, 8'h01, 8'h80, 8'h7F, 8'hE0, 1'b0, 1'b0);
    drive_command(OP_BRIGHT, 8'h03, 8'hFF, 8'hFF, 8'hFF, 8'h55, 1'b0, 1'b0);
    drive_command(OP_OFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0);
    // on keeps the stored color
    drive_command(OP_ON, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    drive_command(OP_UPDATE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    // undefined opcodes: no state change, so the next update stays silent
    drive_command(OP_RSVD_A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    drive_command(OP_RSVD_B, 8'h00, 8'h12, 8'h34, 8'h56, 8'h1F, 1'b1, 1'b0);
    drive_command(OP_UPDATE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    // out-of-range index: no LED changes, but the frame is marked modified
    drive_command(OP_COLOR_FULL, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h00, 1'b0, 1'b0);
    drive_command(OP_BRIGHT, 8'(LED_COUNT), 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    drive_command(OP_UPDATE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    // mostly broadcast writes, which ignore led_index
    drive_command(OP_COLOR_LEVEL, 8'hC8, 8'h12, 8'h34, 8'h56, 8'h1F, 1'b1, 1'b0);
    drive_command(OP_OFF, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
    drive_command(OP_ON, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    drive_command(OP_BRIGHT, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h0A, 1'b1, 1'b0);
    drive_command(OP_UPDATE, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);

    // --- random ---
    // Mostly writes, about one update in five; ignored opcodes are sprinkled
    // in but do not count toward the total.
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_COMMANDS) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) code = ($urandom_range(0, 1) != 0) ? OP_RSVD_A : OP_RSVD_B;
      else if (sel < 24) code = OP_UPDATE;
      else code = write_ops[$urandom_range(0, 4)];
      idx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, LED_COUNT - 1))
                                        : 8'($urandom_range(0, 255));
      drive_command(code, idx, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    ($urandom_range(0, 9) == 0), ($urandom_range(0, 3) == 0));
      if (code != OP_RSVD_A && code != OP_RSVD_B) sent++;
      // hold the sender once until the output side has fully drained
      if (!drained && sent >= RANDOM_COMMANDS / 2) begin
        wait_frames_out();
        drained = 1'b1;
      end
    end

    wait_frames_out();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
